// ----- hw/rtl/dllm_pkg.sv -----
// Shared types and codes of the doubly linked list manager.
package dllm_pkg;

	// request codes
	localparam logic [3:0] REQ_INS_FIRST  = 4'd0;
	localparam logic [3:0] REQ_INS_LAST   = 4'd1;
	localparam logic [3:0] REQ_REM_FIRST  = 4'd2;
	localparam logic [3:0] REQ_REM_LAST   = 4'd3;
	localparam logic [3:0] REQ_PEEK_FIRST = 4'd4;
	localparam logic [3:0] REQ_PEEK_LAST  = 4'd5;
	localparam logic [3:0] REQ_INS_AFTER  = 4'd6;
	localparam logic [3:0] REQ_INS_BEFORE = 4'd7;
	localparam logic [3:0] REQ_REM_AFTER  = 4'd8;
	localparam logic [3:0] REQ_REM_BEFORE = 4'd9;

	// status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EMPTY       = 3'd1;
	localparam logic [2:0] ST_NOT_ALLOWED = 3'd2;
	localparam logic [2:0] ST_FULL        = 3'd3;
	localparam logic [2:0] ST_NOT_IN_USE  = 3'd4;

	typedef struct packed {
		logic [3:0]         req_type;
		logic signed [31:0] item_value;
		logic [8:0]         anchor;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [8:0]         new_handle;
		logic [2:0]         status;
		logic [8:0]         occupancy;
	} rsp_t;

	typedef enum logic [1:0] {OP_NONE, OP_INS, OP_REM, OP_PEEK} op_kind_t;
	typedef enum logic [1:0] {AM_FIRST, AM_LAST, AM_AFTER, AM_BEFORE} anch_mode_t;

	// classified request handed from front to back
	typedef struct packed {
		op_kind_t           kind;
		anch_mode_t         mode;
		logic signed [31:0] value;
		logic [8:0]         anchor;
	} cmd_t;

endpackage

// ----- hw/rtl/dllm_front.sv -----
// Front end: accepts request words, classifies them and queues them for the back end.
module dllm_front import dllm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_word,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_take
);

	cmd_t       dec;
	cmd_t       fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify the request code
	always_comb begin
		dec.value  = in_word.item_value;
		dec.anchor = in_word.anchor;
		dec.kind   = OP_NONE;
		dec.mode   = AM_FIRST;
		unique case (in_word.req_type)
			REQ_INS_FIRST: begin dec.kind = OP_INS; dec.mode = AM_FIRST; end
			REQ_INS_LAST: begin dec.kind = OP_INS; dec.mode = AM_LAST; end
			REQ_REM_FIRST: begin dec.kind = OP_REM; dec.mode = AM_FIRST; end
			REQ_REM_LAST: begin dec.kind = OP_REM; dec.mode = AM_LAST; end
			REQ_PEEK_FIRST: begin dec.kind = OP_PEEK; dec.mode = AM_FIRST; end
			REQ_PEEK_LAST: begin dec.kind = OP_PEEK; dec.mode = AM_LAST; end
			REQ_INS_AFTER: begin dec.kind = OP_INS; dec.mode = AM_AFTER; end
			REQ_INS_BEFORE: begin dec.kind = OP_INS; dec.mode = AM_BEFORE; end
			REQ_REM_AFTER: begin dec.kind = OP_REM; dec.mode = AM_AFTER; end
			REQ_REM_BEFORE: begin dec.kind = OP_REM; dec.mode = AM_BEFORE; end
			default: begin dec.kind = OP_NONE; dec.mode = AM_FIRST; end
		endcase
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	// store classified words
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= dec;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_take) begin
				rd_q <= !rd_q;
			end
			if (push && !cmd_take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && cmd_take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/dllm_back.sv -----
// Back end: node memories, free stack and the sequencer that carries out each request.
module dllm_back import dllm_pkg::*; #(
	parameter int NODE_SLOTS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	output logic out_valid,
	output rsp_t out_word,
	input  logic out_stall
);

	localparam int IW = $clog2(NODE_SLOTS);
	localparam int HR = $clog2(NODE_SLOTS + 2);
	localparam int HW = (HR > 9) ? HR : 9;
	localparam int CW = $clog2(NODE_SLOTS + 1);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_GET, S_WR, S_OUT} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [HW-1:0]           head_q;
	logic [HW-1:0]           tail_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           free_top_q;
	logic [CW-1:0]           lw_q;
	logic [NODE_SLOTS-1:0]   used_q;
	logic [HW-1:0]           a_q;
	logic [HW-1:0]           b_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           stk_pos_q;
	logic                    stk_fresh_q;
	logic signed [31:0]      res_value_q;
	logic [HW-1:0]           res_handle_q;
	logic [2:0]              res_status_q;
	logic                    out_valid_q;
	rsp_t                    out_q;

	// node memories and free stack
	logic signed [31:0] data_mem  [NODE_SLOTS];
	logic [HW-1:0]      next_mem  [NODE_SLOTS];
	logic [HW-1:0]      prev_mem  [NODE_SLOTS];
	logic [IW-1:0]      stack_mem [NODE_SLOTS];
	logic signed [31:0] data_rd;
	logic [HW-1:0]      next_rd;
	logic [HW-1:0]      prev_rd;
	logic [IW-1:0]      stack_rd;

	logic               data_we, next_we, prev_we, stack_we;
	logic [IW-1:0]      data_wa, next_wa, prev_wa, stack_wa;
	logic [IW-1:0]      data_ra, next_ra, prev_ra, stack_ra;
	logic signed [31:0] data_wd;
	logic [HW-1:0]      next_wd, prev_wd;
	logic [IW-1:0]      stack_wd;

	// request checks
	logic [HW-1:0] p_h, p_off;
	logic [IW-1:0] p_idx;
	logic          p_ent, empty, full, anchored;
	logic [2:0]    chk;
	logic [CW-1:0] stk_pos_c;

	// resolved handles
	logic [HW-1:0] pq_h, pq_off, a_h, b_h, n_h, n_off, new_h;
	logic [HW-1:0] a_off, b_off, pp_off, q_off;
	logic [IW-1:0] idx_new;
	logic [CW-1:0] top_dec;
	logic [CW+8:0] occ_ext;

	assign empty     = (count_q == '0);
	assign full      = (free_top_q == '0);
	assign p_h       = HW'(cmd.anchor);
	assign p_off     = p_h - HW'(2);
	assign p_idx     = p_off[IW-1:0];
	assign p_ent     = (p_h >= HW'(2)) && (p_off < HW'(NODE_SLOTS)) && used_q[p_idx];
	assign anchored  = (cmd.mode == AM_AFTER) || (cmd.mode == AM_BEFORE);
	assign stk_pos_c = free_top_q - CW'(1);
	assign cmd_take  = (state_q == S_IDLE) && cmd_valid;

	// check the request against the current list
	always_comb begin
		chk = ST_OK;
		case (cmd.kind)
			OP_INS: begin
				if (cmd.mode == AM_AFTER && p_h == HW'(1)) begin
					chk = ST_NOT_ALLOWED;
				end else if (cmd.mode == AM_BEFORE && p_h == '0) begin
					chk = ST_NOT_ALLOWED;
				end else if (anchored && p_h >= HW'(2) && !p_ent) begin
					chk = ST_NOT_IN_USE;
				end else if (full) begin
					chk = ST_FULL;
				end
			end
			OP_REM: begin
				if (empty) begin
					chk = ST_EMPTY;
				end else if (cmd.mode == AM_AFTER && (p_h == HW'(1) || p_h == tail_q)) begin
					chk = ST_NOT_ALLOWED;
				end else if (cmd.mode == AM_BEFORE && (p_h == '0 || p_h == head_q)) begin
					chk = ST_NOT_ALLOWED;
				end else if (anchored && p_h >= HW'(2) && !p_ent) begin
					chk = ST_NOT_IN_USE;
				end
			end
			OP_PEEK: begin
				if (empty) begin
					chk = ST_EMPTY;
				end
			end
			default: chk = ST_OK;
		endcase
	end

	// resolve neighbor handles from the anchor's links
	always_comb begin
		pq_h    = HW'(cmd_q.anchor);
		pq_off  = pq_h - HW'(2);
		idx_new = stk_fresh_q ? (IW'(NODE_SLOTS - 1) - stk_pos_q) : stack_rd;
		new_h   = HW'(idx_q) + HW'(2);
		case (cmd_q.mode)
			AM_FIRST: begin a_h = '0; b_h = head_q; n_h = head_q; end
			AM_LAST: begin a_h = tail_q; b_h = HW'(1); n_h = tail_q; end
			AM_AFTER: begin
				a_h = pq_h;
				b_h = (pq_h == '0) ? head_q : next_rd;
				n_h = b_h;
			end
			default: begin
				a_h = (pq_h == HW'(1)) ? tail_q : prev_rd;
				b_h = pq_h;
				n_h = a_h;
			end
		endcase
		n_off   = n_h - HW'(2);
		a_off   = a_q - HW'(2);
		b_off   = b_q - HW'(2);
		pp_off  = prev_rd - HW'(2);
		q_off   = next_rd - HW'(2);
		top_dec = free_top_q - CW'(1);
		occ_ext = {{9{1'b0}}, count_q};
	end

	// drive memory ports per sequencer step
	always_comb begin
		data_we  = 1'b0;
		next_we  = 1'b0;
		prev_we  = 1'b0;
		stack_we = 1'b0;
		data_wa  = idx_new;
		data_wd  = cmd_q.value;
		next_wa  = idx_new;
		next_wd  = b_h;
		prev_wa  = idx_new;
		prev_wd  = a_h;
		stack_wa = free_top_q[IW-1:0];
		stack_wd = idx_q;
		data_ra  = n_off[IW-1:0];
		next_ra  = p_idx;
		prev_ra  = p_idx;
		stack_ra = stk_pos_c[IW-1:0];
		case (state_q)
			S_RD: begin
				next_ra = n_off[IW-1:0];
				prev_ra = n_off[IW-1:0];
				if (cmd_q.kind == OP_INS) begin
					data_we = 1'b1;
					next_we = 1'b1;
					prev_we = 1'b1;
				end
			end
			S_GET: begin
				if (cmd_q.kind == OP_REM) begin
					next_we  = (prev_rd != '0);
					next_wa  = pp_off[IW-1:0];
					next_wd  = next_rd;
					prev_we  = (next_rd != HW'(1));
					prev_wa  = q_off[IW-1:0];
					prev_wd  = prev_rd;
					stack_we = (free_top_q < CW'(NODE_SLOTS));
				end
			end
			S_WR: begin
				next_we = (a_q != '0);
				next_wa = a_off[IW-1:0];
				next_wd = new_h;
				prev_we = (b_q != HW'(1));
				prev_wa = b_off[IW-1:0];
				prev_wd = new_h;
			end
			default: ;
		endcase
	end

	// write and read the memories
	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_wa] <= data_wd;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (stack_we) begin
			stack_mem[stack_wa] <= stack_wd;
		end
		data_rd  <= data_mem[data_ra];
		next_rd  <= next_mem[next_ra];
		prev_rd  <= prev_mem[prev_ra];
		stack_rd <= stack_mem[stack_ra];
	end

	// sequence each request and hold the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= HW'(1);
			tail_q       <= '0;
			count_q      <= '0;
			free_top_q   <= CW'(NODE_SLOTS);
			lw_q         <= CW'(NODE_SLOTS);
			used_q       <= '0;
			out_valid_q  <= 1'b0;
			cmd_q        <= '0;
			a_q          <= '0;
			b_q          <= '0;
			idx_q        <= '0;
			stk_pos_q    <= '0;
			stk_fresh_q  <= 1'b0;
			res_value_q  <= '0;
			res_handle_q <= '0;
			res_status_q <= ST_OK;
			out_q        <= '0;
		end else begin
			// raise valid on a new result, drop it once the word is taken
			if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q        <= cmd;
						res_value_q  <= '0;
						res_handle_q <= '0;
						res_status_q <= chk;
						stk_pos_q    <= stk_pos_c[IW-1:0];
						stk_fresh_q  <= (stk_pos_c < lw_q);
						if (chk != ST_OK || cmd.kind == OP_NONE) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (cmd_q.kind == OP_INS) begin
						a_q             <= a_h;
						b_q             <= b_h;
						idx_q           <= idx_new;
						state_q         <= S_WR;
					end else begin
						idx_q   <= n_off[IW-1:0];
						state_q <= S_GET;
					end
				end
				S_GET: begin
					res_value_q <= data_rd;
					if (cmd_q.kind == OP_REM) begin
						if (prev_rd == '0) begin
							head_q <= next_rd;
						end
						if (next_rd == HW'(1)) begin
							tail_q <= prev_rd;
						end
						used_q[idx_q] <= 1'b0;
						if (free_top_q < CW'(NODE_SLOTS)) begin
							free_top_q <= free_top_q + CW'(1);
						end
						if (count_q != '0) begin
							count_q <= count_q - CW'(1);
						end
					end
					state_q <= S_OUT;
				end
				S_WR: begin
					if (a_q == '0) begin
						head_q <= new_h;
					end
					if (b_q == HW'(1)) begin
						tail_q <= new_h;
					end
					used_q[idx_q] <= 1'b1;
					free_top_q <= top_dec;
					if (top_dec < lw_q) begin
						lw_q <= top_dec;
					end
					count_q      <= count_q + CW'(1);
					res_handle_q <= new_h;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q.value_out  <= res_value_q;
						out_q.new_handle <= res_handle_q[8:0];
						out_q.status     <= res_status_q;
						out_q.occupancy  <= occ_ext[8:0];
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// free entries and listed nodes always add up to the store size
	a_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(free_top_q) + 32'(count_q)) == NODE_SLOTS)
		else $error("free count and occupancy disagree");

	// occupancy matches the in-use flags
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == 32'(count_q))
		else $error("in-use flags disagree with occupancy");

	// an empty list has both sentinels linked to each other
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == HW'(1) && tail_q == '0))
		else $error("empty list with dangling end links");

endmodule

// ----- hw/rtl/doubly_linked_list_manager_top.sv -----
// Top level of the doubly linked list manager: request queue front and list back end.
//
//   channel   direction  handshake            word
//   in        input      in_valid/in_stall    req_t  (req_type, item_value, anchor)
//   out       output     out_valid/out_stall  rsp_t  (value_out, new_handle, status, occupancy)
//
// In the back end an accepted request steps through check and read, resolve links,
// write node or neighbors, load result register; a rejected request goes from the
// check to the result register. Each node memory has one read and one write port.
// Reset empties the list and the free stack at once; no clearing pass.
// A two-word queue lets the front keep accepting while the back end is busy,
// and a stalled result stays in its register while the next request is read.
module doubly_linked_list_manager_top import dllm_pkg::*; #(
	parameter int NODE_SLOTS = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_word
);

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;

	dllm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	dllm_back #(.NODE_SLOTS(NODE_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.out_valid (out_valid),
		.out_word  (out_word),
		.out_stall (out_stall)
	);

endmodule

// ----- tb/tb_doubly_linked_list_manager_top.sv -----
// Self-checking testbench for the doubly linked list manager top level.
module tb_doubly_linked_list_manager_top;
	import dllm_pkg::*;

	localparam int SLOTS     = 256;
	localparam int LIMIT     = 400000;
	localparam int HOLD_FROM = 1500;
	localparam int HOLD_LEN  = 400;
	localparam int CALM_FROM = 3000;
	localparam int CALM_TO   = 7000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_word;
	logic out_valid;
	logic out_stall;
	rsp_t out_word;

	doubly_linked_list_manager_top #(.NODE_SLOTS(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	// list shadow kept by the predictor
	logic signed [31:0] shadow_data [SLOTS];
	int  shadow_next [SLOTS];
	int  shadow_prev [SLOTS];
	bit  shadow_used [SLOTS];
	int  free_pool [SLOTS];
	int  free_ptr;
	int  head_ptr;
	int  tail_ptr;
	int  node_count;

	req_t pending_words [$];
	bit   pending_wait [$];
	rsp_t expected_rsp [$];

	int  cycle_cnt;
	int  mismatch_cnt;
	bit  in_took;
	bit  stim_done;

	function automatic bit slot_ok(int h);
		return h >= 2 && h - 2 < SLOTS;
	endfunction

	function automatic bit in_list(int h);
		return slot_ok(h) && shadow_used[h - 2];
	endfunction

	function automatic int after_of(int h);
		if (h == 0)
			return head_ptr;
		if (slot_ok(h))
			return shadow_next[h - 2];
		return 1;
	endfunction

	function automatic int before_of(int h);
		if (h == 1)
			return tail_ptr;
		if (slot_ok(h))
			return shadow_prev[h - 2];
		return 0;
	endfunction

	function automatic void set_after(int h, int v);
		if (h == 0)
			head_ptr = v;
		else if (slot_ok(h))
			shadow_next[h - 2] = v;
	endfunction

	function automatic void set_before(int h, int v);
		if (h == 1)
			tail_ptr = v;
		else if (slot_ok(h))
			shadow_prev[h - 2] = v;
	endfunction

	// place a node behind a, return its handle
	function automatic int splice_in(int a, logic signed [31:0] v);
		int b;
		int idx;
		b = after_of(a);
		free_ptr--;
		idx = free_pool[free_ptr] % SLOTS;
		shadow_data[idx] = v;
		shadow_used[idx] = 1'b1;
		shadow_next[idx] = b;
		shadow_prev[idx] = a;
		set_after(a, idx + 2);
		set_before(b, idx + 2);
		node_count++;
		return idx + 2;
	endfunction

	function automatic logic signed [31:0] splice_out(int n);
		int idx;
		int p;
		int q;
		idx = (n - 2) % SLOTS;
		p = shadow_prev[idx];
		q = shadow_next[idx];
		set_after(p, q);
		set_before(q, p);
		shadow_used[idx] = 1'b0;
		if (free_ptr < SLOTS) begin
			free_pool[free_ptr] = idx;
			free_ptr++;
		end
		if (node_count > 0)
			node_count--;
		return shadow_data[idx];
	endfunction

	function automatic void list_reset();
		for (int i = 0; i < SLOTS; i++) begin
			shadow_used[i] = 1'b0;
			free_pool[i] = SLOTS - 1 - i;
		end
		free_ptr = SLOTS;
		head_ptr = 1;
		tail_ptr = 0;
		node_count = 0;
	endfunction

	// apply one request to the shadow list and return its response
	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int p;
		bit empty;
		bit full;
		p = r.anchor;
		empty = node_count == 0;
		full = free_ptr == 0;
		o = '0;
		case (r.req_type)
			REQ_INS_FIRST, REQ_INS_LAST: begin
				if (full)
					o.status = ST_FULL;
				else
					o.new_handle = 9'(splice_in(r.req_type == REQ_INS_FIRST ? 0 : tail_ptr,
						r.item_value));
			end
			REQ_REM_FIRST, REQ_REM_LAST: begin
				if (empty)
					o.status = ST_EMPTY;
				else
					o.value_out = splice_out(r.req_type == REQ_REM_FIRST ? head_ptr : tail_ptr);
			end
			REQ_PEEK_FIRST, REQ_PEEK_LAST: begin
				if (empty)
					o.status = ST_EMPTY;
				else
					o.value_out = shadow_data[((r.req_type == REQ_PEEK_FIRST ? head_ptr
						: tail_ptr) - 2) % SLOTS];
			end
			REQ_INS_AFTER, REQ_INS_BEFORE: begin
				if ((r.req_type == REQ_INS_AFTER && p == 1) ||
						(r.req_type == REQ_INS_BEFORE && p == 0))
					o.status = ST_NOT_ALLOWED;
				else if (p >= 2 && !in_list(p))
					o.status = ST_NOT_IN_USE;
				else if (full)
					o.status = ST_FULL;
				else
					o.new_handle = 9'(splice_in(r.req_type == REQ_INS_AFTER ? p : before_of(p),
						r.item_value));
			end
			REQ_REM_AFTER: begin
				if (empty)
					o.status = ST_EMPTY;
				else if (p == 1 || p == tail_ptr)
					o.status = ST_NOT_ALLOWED;
				else if (p >= 2 && !in_list(p))
					o.status = ST_NOT_IN_USE;
				else
					o.value_out = splice_out(after_of(p));
			end
			REQ_REM_BEFORE: begin
				if (empty)
					o.status = ST_EMPTY;
				else if (p == 0 || p == head_ptr)
					o.status = ST_NOT_ALLOWED;
				else if (p >= 2 && !in_list(p))
					o.status = ST_NOT_IN_USE;
				else
					o.value_out = splice_out(before_of(p));
			end
			default: ;
		endcase
		o.occupancy = node_count[8:0];
		return o;
	endfunction

	task automatic push_req(logic [3:0] kind, logic signed [31:0] v, logic [8:0] a, bit hold);
		req_t r;
		r.req_type = kind;
		r.item_value = v;
		r.anchor = a;
		pending_words.push_back(r);
		pending_wait.push_back(hold);
		expected_rsp.push_back(list_apply(r));
	endtask

	// pick an anchor: mostly a live node, else a sentinel or any handle
	function automatic logic [8:0] pick_anchor();
		int k;
		int idx;
		k = $urandom_range(0, 99);
		if (k < 75 && node_count > 0) begin
			idx = $urandom_range(0, SLOTS - 1);
			while (!shadow_used[idx])
				idx = $urandom_range(0, SLOTS - 1);
			return 9'(idx + 2);
		end
		if (k < 85)
			return 9'($urandom_range(0, 1));
		if (k < 90)
			return 9'($urandom_range(256, 257));
		return 9'($urandom_range(0, 511));
	endfunction

	function automatic logic [3:0] pick_kind(int ins_bias);
		int k;
		k = $urandom_range(0, 99);
		if (k < 2)
			return 4'($urandom_range(10, 15));
		if (k < ins_bias)
			return $urandom_range(0, 1) ? ($urandom_range(0, 1) ? REQ_INS_FIRST : REQ_INS_LAST)
				: ($urandom_range(0, 1) ? REQ_INS_AFTER : REQ_INS_BEFORE);
		if (k < ins_bias + 12)
			return $urandom_range(0, 1) ? REQ_PEEK_FIRST : REQ_PEEK_LAST;
		case ($urandom_range(0, 3))
			0: return REQ_REM_FIRST;
			1: return REQ_REM_LAST;
			2: return REQ_REM_AFTER;
			default: return REQ_REM_BEFORE;
		endcase
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// reset, stimulus and end of run
	initial begin
		int bias;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		stim_done = 1'b0;
		mismatch_cnt = 0;
		arst_n = 1'b0;
		list_reset();

		// directed: empty list, sentinels, extremes, every operation
		push_req(REQ_REM_FIRST, 32'sd0, 9'd0, 1'b0);
		push_req(REQ_REM_LAST, 32'sd0, 9'd0, 1'b0);
		push_req(REQ_PEEK_FIRST, 32'sd0, 9'd0, 1'b0);
		push_req(REQ_PEEK_LAST, 32'sd0, 9'd0, 1'b0);
		push_req(REQ_REM_AFTER, 32'sd0, 9'd0, 1'b0);
		push_req(REQ_REM_BEFORE, 32'sd0, 9'd1, 1'b0);
		push_req(REQ_INS_AFTER, 32'sd5, 9'd1, 1'b0);
		push_req(REQ_INS_BEFORE, 32'sd5, 9'd0, 1'b0);
		push_req(REQ_INS_AFTER, 32'sd7, 9'd300, 1'b0);
		push_req(REQ_INS_FIRST, 32'h7fffffff, 9'd0, 1'b0);
		push_req(REQ_INS_LAST, 32'h80000000, 9'd0, 1'b0);
		push_req(REQ_INS_AFTER, 32'hffffffff, 9'd0, 1'b0);
		push_req(REQ_INS_BEFORE, 32'sd1, 9'd1, 1'b0);
		push_req(REQ_INS_AFTER, 32'sd2, 9'd257, 1'b0);
		push_req(REQ_INS_BEFORE, 32'sd3, 9'd511, 1'b0);
		push_req(REQ_PEEK_FIRST, 32'sd0, 9'd0, 1'b0);
		push_req(REQ_PEEK_LAST, 32'sd0, 9'd0, 1'b0);
		push_req(REQ_REM_AFTER, 32'sd0, tail_ptr[8:0], 1'b0);
		push_req(REQ_REM_BEFORE, 32'sd0, head_ptr[8:0], 1'b0);
		push_req(REQ_REM_AFTER, 32'sd0, head_ptr[8:0], 1'b0);
		push_req(REQ_REM_BEFORE, 32'sd0, 9'd1, 1'b0);
		push_req(4'd15, 32'h12345678, 9'd3, 1'b0);
		push_req(REQ_REM_FIRST, 32'sd0, 9'd0, 1'b0);
		push_req(REQ_REM_LAST, 32'sd0, 9'd0, 1'b1);

		// random: phases that drift occupancy up and down
		bias = 50;
		for (int i = 0; i < 1500; i++) begin
			if (i % 150 == 0)
				bias = $urandom_range(25, 70);
			// one run to a full store, then a run of inserts against it
			if (i >= 300 && i < 600)
				bias = 85;
			push_req(pick_kind(bias), $urandom, pick_anchor(), i % 400 == 399);
		end
		stim_done = 1'b1;

		repeat (2) @(posedge clk);
		arst_n = 1'b1;

		wait (pending_words.size() == 0 && !in_valid);
		wait (expected_rsp.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// count cycles, stop a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial cycle_cnt = 0;

	// note whether the offered word was taken
	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
	end

	// drive requests from the pending queue
	always @(negedge clk) begin
		bit calm;
		calm = cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO;
		if (arst_n && (!in_valid || in_took)) begin
			if (pending_words.size() != 0 && (pending_wait[0] == 1'b0 ||
					expected_rsp.size() == pending_words.size()) &&
					(calm || $urandom_range(0, 99) >= 32)) begin
				in_word <= pending_words.pop_front();
				void'(pending_wait.pop_front());
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// stall the result channel, with one long hold-off
	always @(negedge clk) begin
		if (cycle_cnt >= HOLD_FROM && cycle_cnt < HOLD_FROM + HOLD_LEN)
			out_stall <= 1'b1;
		else if (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO)
			out_stall <= 1'b0;
		else
			out_stall <= $urandom_range(0, 99) < 32;
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rsp.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result word %h", out_word);
			end else begin
				want = expected_rsp.pop_front();
				if (out_word.value_out !== want.value_out ||
						out_word.new_handle !== want.new_handle ||
						out_word.status !== want.status ||
						out_word.occupancy !== want.occupancy) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("result mismatch: value %0d/%0d handle %0d/%0d status %0d/%0d occ %0d/%0d (exp/act)",
							want.value_out, out_word.value_out,
							want.new_handle, out_word.new_handle,
							want.status, out_word.status,
							want.occupancy, out_word.occupancy);
				end
			end
		end
	end

endmodule
